>>> hw/rtl/gcb_pkg.sv
package gcb_pkg;

  // grapheme break classes
  localparam logic [3:0] GC_OTHER   = 4'd0;
  localparam logic [3:0] GC_CR      = 4'd1;
  localparam logic [3:0] GC_LF      = 4'd2;
  localparam logic [3:0] GC_CONTROL = 4'd3;
  localparam logic [3:0] GC_EXTEND  = 4'd4;
  localparam logic [3:0] GC_RI      = 4'd5;
  localparam logic [3:0] GC_PREPEND = 4'd6;
  localparam logic [3:0] GC_SPACING = 4'd7;
  localparam logic [3:0] GC_L       = 4'd8;
  localparam logic [3:0] GC_V       = 4'd9;
  localparam logic [3:0] GC_T       = 4'd10;
  localparam logic [3:0] GC_LV      = 4'd11;
  localparam logic [3:0] GC_LVT     = 4'd12;
  localparam logic [3:0] GC_ZWJ     = 4'd13;

  // indic conjunct break classes
  localparam logic [1:0] CJ_NONE      = 2'd0;
  localparam logic [1:0] CJ_CONSONANT = 2'd1;
  localparam logic [1:0] CJ_EXTEND    = 2'd2;
  localparam logic [1:0] CJ_LINKER    = 2'd3;

  // conjunct chain states
  localparam logic [1:0] CHAIN_IDLE     = 2'd0;
  localparam logic [1:0] CHAIN_CONS     = 2'd1;
  localparam logic [1:0] CHAIN_OPEN     = 2'd2;
  localparam logic [1:0] CHAIN_RESERVED = 2'd3;

  typedef struct packed {
    logic       start_of_text;
    logic [3:0] break_class;
    logic [1:0] conjunct_class;
    logic       pictographic;
  } gcb_item_t;

  typedef struct packed {
    logic [3:0] last_class;
    logic       indicator_odd;
    logic       zwj_armed;
    logic       emoji_prefix;
    logic [1:0] conjunct_chain;
  } gcb_ctx_t;

endpackage

>>> hw/rtl/gcb_rules.sv
module gcb_rules (
  input  gcb_pkg::gcb_item_t item,
  input  gcb_pkg::gcb_ctx_t  ctx,
  output logic               boundary,
  output gcb_pkg::gcb_ctx_t  ctx_nxt
);
  import gcb_pkg::*;

  logic       brk;
  logic [3:0] p;
  logic [3:0] c;
  logic       c_ctrl;
  logic       p_ctrl;
  logic       joiner;

  assign p      = ctx.last_class;
  assign c      = item.break_class;
  assign c_ctrl = (c == GC_CONTROL) || (c == GC_CR) || (c == GC_LF);
  assign p_ctrl = (p == GC_CONTROL) || (p == GC_CR) || (p == GC_LF);
  assign joiner = (c == GC_EXTEND) || (c == GC_ZWJ);

  // boundary rules, highest priority first
  always_comb begin
    if (item.start_of_text) begin
      brk = 1'b1;
    end else if ((p == GC_CR) && (c == GC_LF)) begin
      brk = 1'b0;
    end else if (p_ctrl || c_ctrl) begin
      brk = 1'b1;
    end else if ((p == GC_L) &&
                 ((c == GC_L) || (c == GC_V) || (c == GC_LV) || (c == GC_LVT))) begin
      brk = 1'b0;
    end else if (((p == GC_LV) || (p == GC_V)) && ((c == GC_V) || (c == GC_T))) begin
      brk = 1'b0;
    end else if (((p == GC_LVT) || (p == GC_T)) && (c == GC_T)) begin
      brk = 1'b0;
    end else if (joiner || (c == GC_SPACING) || (p == GC_PREPEND)) begin
      brk = 1'b0;
    end else if ((ctx.conjunct_chain == CHAIN_OPEN) &&
                 (item.conjunct_class == CJ_CONSONANT)) begin
      brk = 1'b0;
    end else if (ctx.zwj_armed && item.pictographic) begin
      brk = 1'b0;
    end else if ((p == GC_RI) && (c == GC_RI) && ctx.indicator_odd) begin
      brk = 1'b0;
    end else begin
      brk = 1'b1;
    end
  end

  assign boundary = brk;

  // context for the next item
  always_comb begin
    ctx_nxt = ctx;
    if (brk) begin
      ctx_nxt.last_class     = c;
      ctx_nxt.indicator_odd  = (c == GC_RI);
      ctx_nxt.zwj_armed      = 1'b0;
      ctx_nxt.emoji_prefix   = item.pictographic;
      ctx_nxt.conjunct_chain = (item.conjunct_class == CJ_CONSONANT) ? CHAIN_CONS
                                                                     : CHAIN_IDLE;
    end else begin
      ctx_nxt.last_class    = c;
      ctx_nxt.indicator_odd = (c == GC_RI) ? ~ctx.indicator_odd : 1'b0;

      if (c == GC_ZWJ) begin
        ctx_nxt.zwj_armed    = ctx.emoji_prefix;
        ctx_nxt.emoji_prefix = 1'b0;
      end else if (item.pictographic) begin
        ctx_nxt.zwj_armed    = 1'b0;
        ctx_nxt.emoji_prefix = 1'b1;
      end else if (c == GC_EXTEND) begin
        ctx_nxt.zwj_armed    = 1'b0;
      end else begin
        ctx_nxt.zwj_armed    = 1'b0;
        ctx_nxt.emoji_prefix = 1'b0;
      end

      case (item.conjunct_class)
        CJ_LINKER: begin
          if ((ctx.conjunct_chain == CHAIN_CONS) || (ctx.conjunct_chain == CHAIN_OPEN)) begin
            ctx_nxt.conjunct_chain = CHAIN_OPEN;
          end
        end
        CJ_CONSONANT: begin
          ctx_nxt.conjunct_chain = CHAIN_CONS;
        end
        CJ_NONE: begin
          if (!joiner) begin
            ctx_nxt.conjunct_chain = CHAIN_IDLE;
          end
        end
        default: begin
          ctx_nxt.conjunct_chain = ctx.conjunct_chain;
        end
      endcase
    end
  end

endmodule

>>> hw/rtl/grapheme_cluster_break_detector.sv
// Grapheme cluster boundary detector after UAX #29 (GB3 to GB13 and GB9c).
// Each item carries one code point's break class, Indic conjunct class and
// Extended_Pictographic flag; each result says whether a cluster boundary
// falls before that code point. Items pass an input register, then the rule
// logic, then a result register, and one item is taken every cycle as long as
// results are taken; the rule evaluation with its context feedback is
// combinational, which sets that rate. The first item of a
// text and every item that opens a cluster rebuild the context from the
// item alone. After reset the context acts as a preceding Other code point.
module grapheme_cluster_break_detector (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic       in_start_of_text,
  input  logic [3:0] in_break_class,
  input  logic [1:0] in_conjunct_class,
  input  logic       in_pictographic,
  output logic       out_vld,
  input  logic       out_ready,
  output logic       out_boundary_before
);
  import gcb_pkg::*;

  // input stage
  logic      s1_valid_r;
  gcb_item_t s1_item_r;

  // cluster context carried between items
  gcb_ctx_t ctx_r;
  gcb_ctx_t ctx_nxt;

  // result stage
  logic out_vld_r;
  logic out_boundary_before_r;

  logic boundary;
  logic out_free;
  logic advance;
  logic accept;

  // the result register frees up in the same cycle its item is taken
  assign out_free = !out_vld_r || out_ready;
  assign advance  = s1_valid_r && out_free;
  assign in_ready = !s1_valid_r || out_free;
  assign accept   = in_valid && in_ready;

  gcb_rules u_rules (
    .item     (s1_item_r),
    .ctx      (ctx_r),
    .boundary (boundary),
    .ctx_nxt  (ctx_nxt)
  );

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (accept) begin
      s1_valid_r <= 1'b1;
    end else if (advance) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_item_r.start_of_text  <= in_start_of_text;
      s1_item_r.break_class    <= in_break_class;
      s1_item_r.conjunct_class <= in_conjunct_class;
      s1_item_r.pictographic   <= in_pictographic;
    end
  end

  // context only moves when an item leaves the input stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctx_r <= '0;
    end else if (advance) begin
      ctx_r <= ctx_nxt;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (advance) begin
      out_vld_r <= 1'b1;
    end else if (out_ready) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_boundary_before_r <= boundary;
    end
  end

  assign out_vld             = out_vld_r;
  assign out_boundary_before = out_boundary_before_r;

  // start of text always reports a boundary
  a_sot_breaks: assert property (@(posedge clk) disable iff (!rst_n)
    (advance && s1_item_r.start_of_text) |=> out_boundary_before)
    else $error("start of text item without boundary");

  // chain never reaches the unused code
  a_chain_code: assert property (@(posedge clk) disable iff (!rst_n)
    ctx_r.conjunct_chain != CHAIN_RESERVED)
    else $error("conjunct chain in reserved state");

  // an armed joiner is always the last code point
  a_zwj_last: assert property (@(posedge clk) disable iff (!rst_n)
    ctx_r.zwj_armed |-> (ctx_r.last_class == GC_ZWJ))
    else $error("zwj armed without zwj as last class");

  // armed joiner and open emoji prefix exclude each other
  a_zwj_prefix: assert property (@(posedge clk) disable iff (!rst_n)
    !(ctx_r.zwj_armed && ctx_r.emoji_prefix))
    else $error("zwj armed together with emoji prefix");

  // odd indicator parity only right after an indicator
  a_ri_parity: assert property (@(posedge clk) disable iff (!rst_n)
    ctx_r.indicator_odd |-> (ctx_r.last_class == GC_RI))
    else $error("indicator parity set after non indicator");

endmodule
